### src/gedt_pkg.sv
// Shared types and constants of the grid distance transform.
package gedt_pkg;

   // Grid geometry
   localparam int X_BITS    = 8;
   localparam int Y_BITS    = 8;
   localparam int ADDR_BITS = X_BITS + Y_BITS;
   localparam int DIM_BITS  = 9;
   localparam int CELLS     = 1 << ADDR_BITS;
   localparam int COLS      = 1 << X_BITS;

   // Arithmetic widths
   localparam int SQ_BITS   = 17;
   localparam int NUM_BITS  = 19;
   localparam int DEN_BITS  = 10;
   localparam int RES_BITS  = 24;
   localparam int DIST_BITS = 32;
   localparam int ROOT_BITS = 9;
   localparam int THR_BITS  = 8;
   localparam int CSR_BITS  = 24;

   localparam logic [DIM_BITS-1:0]  MAX_DIM  = 9'd256;
   localparam logic [SQ_BITS-1:0]   SQ_SAT   = 17'h1FFFF;
   localparam logic [DIST_BITS-1:0] DIST_SAT = 32'hFFFF_FFFF;

   // Register indexes
   typedef logic [1:0] csr_idx_type;
   localparam csr_idx_type CSR_GRID_WIDTH  = 2'd0;
   localparam csr_idx_type CSR_GRID_HEIGHT = 2'd1;
   localparam csr_idx_type CSR_THRESHOLD   = 2'd2;
   localparam csr_idx_type CSR_RESOLUTION  = 2'd3;

   // Commands
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // One envelope entry: vertex, its value and the left boundary as a fraction
   typedef struct packed {
      logic [X_BITS-1:0]          v;
      logic [SQ_BITS-1:0]         fv;
      logic signed [NUM_BITS-1:0] bn;
      logic [DEN_BITS-1:0]        bd;
   } env_entry_type;

   // Square root unit control
   typedef struct packed {
      logic               start;
      logic [SQ_BITS-1:0] value;
   } sqrt_req_type;

   typedef struct packed {
      logic                 done;
      logic [ROOT_BITS-1:0] root;
   } sqrt_rsp_type;

endpackage

### src/grid_euclidean_distance_transform.sv
// Top level: occupancy load, two-pass exact distance transform and distance reads.
//
//  channel  | ports                                         | direction
//  ---------+-----------------------------------------------+----------
//  request  | req_valid/req_ready, cmd, occupancy, last, xy | in
//  response | rsp_valid/rsp_ready, squared_cells, dist, flag| out
//  csr      | csr_we, csr_index, csr_wdata                  | in
//
// A load with the last mark starts the transform. Its column pass reads and writes
// each cell down the column, then up; the row pass builds the envelope per cell (read,
// check, then compare, two multiplies and decide per envelope compare) and looks each
// cell up (read, compare and test per boundary left to test, then write; an empty row
// is written unreached). Each step is one access of the distance and envelope memories.
// Each has one write and one registered read port. A read steps through check, square
// root, multiply and output; out of range, before the transform or unreached, it skips
// to output. Reset clears control state only; the memories hold anything until written.
// The request side is ready whenever the sequencer is idle, even while a result waits;
// a following read then holds in its output step until the result register frees.
module grid_euclidean_distance_transform (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_cmd,
   input  logic signed [7:0]                req_occupancy,
   input  logic                             req_last_cell,
   input  logic [gedt_pkg::X_BITS-1:0]      req_read_x,
   input  logic [gedt_pkg::Y_BITS-1:0]      req_read_y,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [gedt_pkg::SQ_BITS-1:0]     rsp_squared_cells,
   output logic [gedt_pkg::DIST_BITS-1:0]   rsp_distance_q16,
   output logic                             rsp_no_obstacle,
   input  logic                             csr_we,
   input  gedt_pkg::csr_idx_type            csr_index,
   input  logic [gedt_pkg::CSR_BITS-1:0]    csr_wdata
);

   typedef enum logic [18:0] {
      ST_IDLE  = 19'h00001,
      ST_CF_RD = 19'h00002,
      ST_CF_WR = 19'h00004,
      ST_CB_RD = 19'h00008,
      ST_CB_WR = 19'h00010,
      ST_B_RD  = 19'h00020,
      ST_B_CHK = 19'h00040,
      ST_B_CMP = 19'h00080,
      ST_B_MA  = 19'h00100,
      ST_B_MB  = 19'h00200,
      ST_B_DEC = 19'h00400,
      ST_Q_RD  = 19'h00800,
      ST_Q_CMP = 19'h01000,
      ST_Q_TST = 19'h02000,
      ST_Q_WR  = 19'h04000,
      ST_R_CHK = 19'h08000,
      ST_R_SQ  = 19'h10000,
      ST_R_MUL = 19'h20000,
      ST_R_OUT = 19'h40000
   } state_type;

   localparam int XB = gedt_pkg::X_BITS;
   localparam int YB = gedt_pkg::Y_BITS;
   localparam int AB = gedt_pkg::ADDR_BITS;
   localparam int DB = gedt_pkg::DIM_BITS;
   localparam int SB = gedt_pkg::SQ_BITS;
   localparam int NB = gedt_pkg::NUM_BITS;
   localparam int EB = gedt_pkg::DEN_BITS;
   localparam int PB = NB + EB + 1;
   localparam int MB = gedt_pkg::ROOT_BITS + gedt_pkg::RES_BITS;

   // Configuration
   logic [DB-1:0]                   gw_ff, gh_ff;
   logic signed [7:0]               thr_ff;
   logic [gedt_pkg::RES_BITS-1:0]   res_ff;
   logic [DB-1:0]                   w_m1, h_m1, eff_w, eff_h;

   // Sequencer and counters
   state_type                        state_ff, state_in;
   logic                             done_ff, done_in;
   logic [XB-1:0]                    lx_ff, lx_in;
   logic [DB-1:0]                    ly_ff, ly_in;
   logic [XB-1:0]                    x_ff, x_in;
   logic [YB-1:0]                    y_ff, y_in;
   logic [XB-1:0]                    last_ff, last_in;
   logic                             have_ff, have_in;
   logic [XB-1:0]                    k_ff, k_in;
   logic [XB-1:0]                    cur_ff, cur_in;
   logic                             empty_ff, empty_in;
   logic [SB-1:0]                    f_ff, f_in;
   logic signed [NB-1:0]             sn_ff, sn_in, bn_ff, bn_in;
   logic [EB-1:0]                    sd_ff, sd_in, bd_ff, bd_in;
   logic signed [PB-1:0]             pa_ff, pa_in, pb_ff, pb_in;
   logic [XB+EB-1:0]                 pq_ff, pq_in;
   logic                             bad_ff, bad_in;
   logic [gedt_pkg::ROOT_BITS-1:0]   root_ff, root_in;
   logic [SB-1:0]                    sq_ff, sq_in;
   logic [MB-1:0]                    prod_ff, prod_in;

   // Result register
   logic                             rv_ff, rv_in;
   logic [SB-1:0]                    rsq_ff, rsq_in;
   logic [gedt_pkg::DIST_BITS-1:0]   rdist_ff, rdist_in;
   logic                             rno_ff, rno_in;

   // Memories
   logic                             obs_mem [gedt_pkg::CELLS];
   logic [SB:0]                      dist_mem [gedt_pkg::CELLS];
   gedt_pkg::env_entry_type          env_mem [gedt_pkg::COLS];
   logic                             obs_we, obs_wd, obs_q_ff;
   logic [AB-1:0]                    obs_wa, obs_ra;
   logic                             dist_we;
   logic [AB-1:0]                    dist_wa, dist_ra;
   logic [SB:0]                      dist_wd, dist_q_ff;
   logic                             env_we;
   logic [XB-1:0]                    env_wa, env_ra;
   gedt_pkg::env_entry_type          env_wd, env_q_ff;

   gedt_pkg::sqrt_req_type           sq_req;
   gedt_pkg::sqrt_rsp_type           sq_rsp;

   // Scratch of the datapath
   logic                             accept, have_now;
   logic [XB-1:0]                    last_now, dx, dy;
   logic [SB-1:0]                    dsq;
   logic [SB:0]                      lhs, rhs;
   logic [XB-1:0]                    nx;

   gedt_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .req_in  (sq_req),
      .rsp_out (sq_rsp)
   );

   // Clamp the grid size into range
   always_comb begin
      if (gw_ff == '0) begin
         w_m1 = '0;
      end else if (gw_ff > gedt_pkg::MAX_DIM) begin
         w_m1 = gedt_pkg::MAX_DIM - DB'(1);
      end else begin
         w_m1 = gw_ff - DB'(1);
      end
      if (gh_ff == '0) begin
         h_m1 = '0;
      end else if (gh_ff > gedt_pkg::MAX_DIM) begin
         h_m1 = gedt_pkg::MAX_DIM - DB'(1);
      end else begin
         h_m1 = gh_ff - DB'(1);
      end
      eff_w = w_m1 + DB'(1);
      eff_h = h_m1 + DB'(1);
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      done_in  = done_ff;
      lx_in    = lx_ff;
      ly_in    = ly_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      last_in  = last_ff;
      have_in  = have_ff;
      k_in     = k_ff;
      cur_in   = cur_ff;
      empty_in = empty_ff;
      f_in     = f_ff;
      sn_in    = sn_ff;
      sd_in    = sd_ff;
      bn_in    = bn_ff;
      bd_in    = bd_ff;
      pa_in    = pa_ff;
      pb_in    = pb_ff;
      pq_in    = pq_ff;
      bad_in   = bad_ff;
      root_in  = root_ff;
      sq_in    = sq_ff;
      prod_in  = prod_ff;
      rsq_in   = rsq_ff;
      rdist_in = rdist_ff;
      rno_in   = rno_ff;
      rv_in    = rv_ff && !rsp_ready;
      obs_we   = 1'b0;
      obs_wa   = {ly_ff[YB-1:0], lx_ff};
      obs_wd   = (req_occupancy > thr_ff);
      obs_ra   = {y_ff, x_ff};
      dist_we  = 1'b0;
      dist_wa  = {y_ff, x_ff};
      dist_wd  = '0;
      dist_ra  = {y_ff, x_ff};
      env_we   = 1'b0;
      env_wa   = '0;
      env_wd   = '0;
      env_ra   = k_ff;
      sq_req   = '0;
      have_now = have_ff || obs_q_ff;
      last_now = obs_q_ff ? y_ff : last_ff;
      dx       = '0;
      dy       = '0;
      dsq      = '0;
      lhs      = '0;
      rhs      = '0;
      nx       = x_ff + XB'(1);

      case (state_ff)
         ST_IDLE: begin
            if (accept && req_cmd == gedt_pkg::CMD_LOAD) begin
               // store the obstacle decision and advance the load position
               done_in = 1'b0;
               if (ly_ff < eff_h) begin
                  obs_we = 1'b1;
                  if ({1'b0, lx_ff} == w_m1) begin
                     lx_in = '0;
                     ly_in = ly_ff + DB'(1);
                  end else begin
                     lx_in = lx_ff + XB'(1);
                  end
               end
               if (req_last_cell) begin
                  lx_in    = '0;
                  ly_in    = '0;
                  x_in     = '0;
                  y_in     = '0;
                  have_in  = 1'b0;
                  state_in = ST_CF_RD;
               end
            end else if (accept) begin
               dist_ra  = {req_read_y, req_read_x};
               bad_in   = !done_ff || ({1'b0, req_read_x} >= eff_w) ||
                          ({1'b0, req_read_y} >= eff_h);
               state_in = ST_R_CHK;
            end
         end

         ST_CF_RD: state_in = ST_CF_WR;

         ST_CF_WR: begin
            // forward sweep down the column
            have_in = have_now;
            last_in = last_now;
            dy      = y_ff - last_now;
            dist_we = 1'b1;
            dist_wd = have_now ? {1'b1, SB'(dy * dy)} : '0;
            if ({1'b0, y_ff} == h_m1) begin
               have_in  = 1'b0;
               state_in = ST_CB_RD;
            end else begin
               y_in     = y_ff + YB'(1);
               state_in = ST_CF_RD;
            end
         end

         ST_CB_RD: state_in = ST_CB_WR;

         ST_CB_WR: begin
            // backward sweep up the column, keep the nearer obstacle
            have_in = have_now;
            last_in = last_now;
            dy      = last_now - y_ff;
            dsq     = SB'(dy * dy);
            if (have_now && (!dist_q_ff[SB] || dsq < dist_q_ff[SB-1:0])) begin
               dist_we = 1'b1;
               dist_wd = {1'b1, dsq};
            end
            if (y_ff == '0) begin
               have_in = 1'b0;
               if ({1'b0, x_ff} == w_m1) begin
                  x_in     = '0;
                  empty_in = 1'b1;
                  k_in     = '0;
                  state_in = ST_B_RD;
               end else begin
                  x_in     = nx;
                  state_in = ST_CF_RD;
               end
            end else begin
               y_in     = y_ff - YB'(1);
               state_in = ST_CB_RD;
            end
         end

         ST_B_RD: state_in = ST_B_CHK;

         ST_B_CHK: begin
            // take the column value of this cell into the envelope
            f_in = dist_q_ff[SB-1:0];
            if (!dist_q_ff[SB]) begin
               if ({1'b0, x_ff} == w_m1) begin
                  x_in = '0; cur_in = '0; state_in = ST_Q_RD;
               end else begin
                  x_in = nx; state_in = ST_B_RD;
               end
            end else if (empty_ff) begin
               env_we   = 1'b1;
               env_wa   = '0;
               env_wd   = '{v: x_ff, fv: dist_q_ff[SB-1:0], bn: '0, bd: '0};
               empty_in = 1'b0;
               k_in     = '0;
               if ({1'b0, x_ff} == w_m1) begin
                  x_in = '0; cur_in = '0; state_in = ST_Q_RD;
               end else begin
                  x_in = nx; state_in = ST_B_RD;
               end
            end else begin
               env_ra   = k_ff;
               state_in = ST_B_CMP;
            end
         end

         ST_B_CMP: begin
            // intersection with the top parabola as numerator over denominator
            lhs      = (SB+1)'(f_ff) + (SB+1)'(x_ff * x_ff);
            rhs      = (SB+1)'(env_q_ff.fv) + (SB+1)'(env_q_ff.v * env_q_ff.v);
            sn_in    = $signed({1'b0, lhs}) - $signed({1'b0, rhs});
            sd_in    = {1'b0, x_ff - env_q_ff.v, 1'b0};
            bn_in    = env_q_ff.bn;
            bd_in    = env_q_ff.bd;
            state_in = ST_B_MA;
         end

         ST_B_MA: begin
            pa_in    = sn_ff * $signed({1'b0, bd_ff});
            state_in = ST_B_MB;
         end

         ST_B_MB: begin
            pb_in    = bn_ff * $signed({1'b0, sd_ff});
            state_in = ST_B_DEC;
         end

         ST_B_DEC: begin
            // drop the top vertex while the new one hides it, else push
            if (k_ff != '0 && pa_ff <= pb_ff) begin
               k_in     = k_ff - XB'(1);
               env_ra   = k_ff - XB'(1);
               state_in = ST_B_CMP;
            end else begin
               env_we = 1'b1;
               env_wa = k_ff + XB'(1);
               env_wd = '{v: x_ff, fv: f_ff, bn: sn_ff, bd: sd_ff};
               k_in   = k_ff + XB'(1);
               if ({1'b0, x_ff} == w_m1) begin
                  x_in = '0; cur_in = '0; state_in = ST_Q_RD;
               end else begin
                  x_in = nx; state_in = ST_B_RD;
               end
            end
         end

         ST_Q_RD: begin
            if (empty_ff) begin
               dist_we = 1'b1;
               dist_wd = '0;
               if ({1'b0, x_ff} == w_m1) begin
                  x_in = '0;
                  if ({1'b0, y_ff} == h_m1) begin
                     done_in = 1'b1; state_in = ST_IDLE;
                  end else begin
                     y_in = y_ff + YB'(1); empty_in = 1'b1; k_in = '0; state_in = ST_B_RD;
                  end
               end else begin
                  x_in = nx;
               end
            end else if (cur_ff < k_ff) begin
               env_ra   = cur_ff + XB'(1);
               state_in = ST_Q_CMP;
            end else begin
               env_ra   = cur_ff;
               state_in = ST_Q_WR;
            end
         end

         ST_Q_CMP: begin
            pq_in    = x_ff * env_q_ff.bd;
            bn_in    = env_q_ff.bn;
            state_in = ST_Q_TST;
         end

         ST_Q_TST: begin
            // advance past boundaries left of this cell
            if ($signed({bn_ff[NB-1], bn_ff}) < $signed({2'b00, pq_ff})) begin
               cur_in   = cur_ff + XB'(1);
               state_in = ST_Q_RD;
            end else begin
               env_ra   = cur_ff;
               state_in = ST_Q_WR;
            end
         end

         ST_Q_WR: begin
            dx      = (x_ff > env_q_ff.v) ? x_ff - env_q_ff.v : env_q_ff.v - x_ff;
            dist_we = 1'b1;
            dist_wd = {1'b1, SB'(dx * dx) + env_q_ff.fv};
            if ({1'b0, x_ff} == w_m1) begin
               x_in = '0;
               if ({1'b0, y_ff} == h_m1) begin
                  done_in = 1'b1; state_in = ST_IDLE;
               end else begin
                  y_in = y_ff + YB'(1); empty_in = 1'b1; k_in = '0; state_in = ST_B_RD;
               end
            end else begin
               x_in = nx; state_in = ST_Q_RD;
            end
         end

         ST_R_CHK: begin
            // mark unreached cells; the result register is left alone here
            if (bad_ff || !dist_q_ff[SB]) begin
               bad_in   = 1'b1;
               state_in = ST_R_OUT;
            end else begin
               sq_in        = dist_q_ff[SB-1:0];
               sq_req.start = 1'b1;
               sq_req.value = dist_q_ff[SB-1:0];
               state_in     = ST_R_SQ;
            end
         end

         ST_R_SQ: begin
            if (sq_rsp.done) begin
               root_in  = sq_rsp.root;
               state_in = ST_R_MUL;
            end
         end

         ST_R_MUL: begin
            prod_in  = MB'(root_ff) * MB'(res_ff);
            state_in = ST_R_OUT;
         end

         ST_R_OUT: begin
            // hold until the result register is free
            if (!rv_ff || rsp_ready) begin
               rv_in  = 1'b1;
               rno_in = bad_ff;
               if (bad_ff) begin
                  rsq_in   = gedt_pkg::SQ_SAT;
                  rdist_in = gedt_pkg::DIST_SAT;
               end else begin
                  rsq_in   = sq_ff;
                  rdist_in = prod_ff[MB-1] ? gedt_pkg::DIST_SAT
                                           : prod_ff[gedt_pkg::DIST_BITS-1:0];
               end
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // size writes restart the load and invalidate the distances
      if (csr_we && (csr_index == gedt_pkg::CSR_GRID_WIDTH ||
                     csr_index == gedt_pkg::CSR_GRID_HEIGHT)) begin
         done_in = 1'b0;
         lx_in   = '0;
         ly_in   = '0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
         lx_ff    <= '0;
         ly_ff    <= '0;
         rv_ff    <= 1'b0;
         gw_ff    <= gedt_pkg::MAX_DIM;
         gh_ff    <= gedt_pkg::MAX_DIM;
         thr_ff   <= 8'sd50;
         res_ff   <= 24'd3277;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         lx_ff    <= lx_in;
         ly_ff    <= ly_in;
         rv_ff    <= rv_in;
         if (csr_we) begin
            case (csr_index)
               gedt_pkg::CSR_GRID_WIDTH:  gw_ff  <= csr_wdata[DB-1:0];
               gedt_pkg::CSR_GRID_HEIGHT: gh_ff  <= csr_wdata[DB-1:0];
               gedt_pkg::CSR_THRESHOLD:   thr_ff <= $signed(csr_wdata[gedt_pkg::THR_BITS-1:0]);
               gedt_pkg::CSR_RESOLUTION:  res_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      last_ff  <= last_in;
      have_ff  <= have_in;
      k_ff     <= k_in;
      cur_ff   <= cur_in;
      empty_ff <= empty_in;
      f_ff     <= f_in;
      sn_ff    <= sn_in;
      sd_ff    <= sd_in;
      bn_ff    <= bn_in;
      bd_ff    <= bd_in;
      pa_ff    <= pa_in;
      pb_ff    <= pb_in;
      pq_ff    <= pq_in;
      bad_ff   <= bad_in;
      root_ff  <= root_in;
      sq_ff    <= sq_in;
      prod_ff  <= prod_in;
      rsq_ff   <= rsq_in;
      rdist_ff <= rdist_in;
      rno_ff   <= rno_in;
   end

   // Memories: one write and one registered read each
   always_ff @(posedge clock) begin
      if (obs_we) begin
         obs_mem[obs_wa] <= obs_wd;
      end
      obs_q_ff <= obs_mem[obs_ra];
   end

   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem[dist_wa] <= dist_wd;
      end
      dist_q_ff <= dist_mem[dist_ra];
   end

   always_ff @(posedge clock) begin
      if (env_we) begin
         env_mem[env_wa] <= env_wd;
      end
      env_q_ff <= env_mem[env_ra];
   end

   assign rsp_valid         = rv_ff;
   assign rsp_squared_cells = rsq_ff;
   assign rsp_distance_q16  = rdist_ff;
   assign rsp_no_obstacle   = rno_ff;

   // Envelope stack never holds more vertices than columns seen
   a_stack_depth: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_B_DEC) |-> (k_ff < x_ff))
      else $error("envelope depth exceeds scanned columns");

   // Lookup pointer stays inside the envelope
   a_cursor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_Q_TST) |-> (cur_ff < k_ff))
      else $error("lookup cursor beyond envelope");

   // Written distances fit the largest grid
   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_Q_WR) |-> (dist_wd[SB-1:0] <= 17'd130050))
      else $error("distance beyond grid diagonal");

   // Completion only at the end of the row pass
   a_done_src: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> ($past(state_ff) == ST_Q_WR || $past(state_ff) == ST_Q_RD))
      else $error("transform finished outside the row pass");

endmodule

### src/gedt_isqrt.sv
// Iterative integer square root by digit recurrence; a new start restarts it even while busy.
module gedt_isqrt (
   input  logic                 clock,
   input  logic                 reset,
   input  gedt_pkg::sqrt_req_type req_in,
   output gedt_pkg::sqrt_rsp_type rsp_out
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [gedt_pkg::SQ_BITS:0]  rem_ff, rem_in;
   logic [gedt_pkg::SQ_BITS:0]  res_ff, res_in;
   logic [gedt_pkg::SQ_BITS:0]  bit_ff, bit_in;
   logic [gedt_pkg::SQ_BITS:0]  trial;

   // Step the digit recurrence until the lowest bit is consumed
   always_comb begin
      trial   = res_ff + bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (req_in.start) begin
         busy_in = 1'b1;
         rem_in  = {1'b0, req_in.value};
         res_in  = '0;
         bit_in  = (gedt_pkg::SQ_BITS+1)'(1) << (gedt_pkg::SQ_BITS - 1);
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign rsp_out.done = done_ff;
   assign rsp_out.root = res_ff[gedt_pkg::ROOT_BITS-1:0];

endmodule
